// ===== rtl/cowrt_pkg.sv =====
package cowrt_pkg;

  localparam int DEF_TABLE_ENTRIES = 2048;
  localparam int DEF_COUNT_WIDTH   = 16;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 16;
  localparam int ST_W    = 2;
  localparam int CNT_O_W = 16;
  localparam int SLOT_W  = 11;
  localparam int FREE_W  = 12;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  localparam logic [OP_W-1:0] OP_SET = 3'd0;
  localparam logic [OP_W-1:0] OP_INC = 3'd1;
  localparam logic [OP_W-1:0] OP_GET = 3'd2;
  localparam logic [OP_W-1:0] OP_DEC = 3'd3;
  localparam logic [OP_W-1:0] OP_REM = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/cowrt_if.sv =====
interface cowrt_req_if;
  import cowrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  frame_addr;
  logic [VAL_W-1:0]  ref_value;
  logic              owned_in;

  modport source (output valid, operation, frame_addr, ref_value, owned_in, input ready);
  modport sink   (input valid, operation, frame_addr, ref_value, owned_in, output ready);
endinterface

interface cowrt_rsp_if;
  import cowrt_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [CNT_O_W-1:0] ref_count;
  logic               owned_out;
  logic [SLOT_W-1:0]  slot_index;
  logic [FREE_W-1:0]  free_slots;

  modport source (output valid, status, ref_count, owned_out, slot_index, free_slots,
                  input ready);
  modport sink   (input valid, status, ref_count, owned_out, slot_index, free_slots,
                  output ready);
endinterface

// ===== rtl/cowrt_store.sv =====
module cowrt_store #(
  parameter int DEPTH  = cowrt_pkg::DEF_TABLE_ENTRIES,
  parameter int DATA_W = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cow_frame_refcount_table_top.sv =====
// Flow: an accepted transaction is hashed in S_HASH and then probes slots from its start slot
// in S_PROBE (1..TABLE_ENTRIES slots); when TABLE_ENTRIES is not a power of two, S_MOD first
// forms the start-slot remainder bit-serially. One table read per cycle in the probe loop; no
// new transaction is taken until the result is registered. Unknown operations complete without
// probing. Reset: synchronous, active low; a clearing pass over all TABLE_ENTRIES slots follows,
// during which no transaction is accepted.
module cow_frame_refcount_table_top #(
  parameter int TABLE_ENTRIES = cowrt_pkg::DEF_TABLE_ENTRIES,
  parameter int COUNT_WIDTH   = cowrt_pkg::DEF_COUNT_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  cowrt_req_if.sink in_req,
  cowrt_rsp_if.source out_rsp
);
  import cowrt_pkg::*;

  localparam int  IW    = $clog2(TABLE_ENTRIES);
  localparam int  FW    = $clog2(TABLE_ENTRIES + 1);
  localparam int  CW    = COUNT_WIDTH;
  localparam int  EW    = KEY_W + CW + 2;
  localparam bit  POW2  = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_MAX   = {CW{1'b1}};

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic [IW-1:0]    n_r, n_nxt;
  logic [IW-1:0]    rem_r, rem_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic [FW-1:0]    free_r, free_nxt;
  logic [KEY_W-1:0] prod_r;
  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    val_r;
  logic             own_r;

  logic               out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]    out_status_r;
  logic [CNT_O_W-1:0] out_count_r;
  logic               out_owned_r;
  logic [SLOT_W-1:0]  out_slot_r;

  logic             we;
  logic [IW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic [EW-1:0]    rd;
  logic             accept;

  logic             e_valid, e_owned, e_match, e_stop, e_last;
  logic [CW-1:0]    e_count, cnt_dec;
  logic [KEY_W-1:0] e_frame;
  logic [IW:0]      mod_sh;
  logic             finish, out_free;
  logic [ST_W-1:0]  res_status;
  logic [CW-1:0]    res_count;
  logic             res_owned;
  logic [IW-1:0]    res_slot;

  cowrt_store #(
    .DEPTH  (TABLE_ENTRIES),
    .DATA_W (EW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (slot_nxt),
    .rdata (rd)
  );

  assign accept        = in_req.valid && in_req.ready;
  assign in_req.ready  = (state_r == S_IDLE);

  assign e_valid = rd[EW-1];
  assign e_owned = rd[EW-2];
  assign e_count = rd[KEY_W +: CW];
  assign e_frame = rd[KEY_W-1:0];
  assign e_match = e_valid && (e_frame == key_r);
  assign e_stop  = !e_valid || e_match;
  assign e_last  = (n_r == LAST_SLOT);
  assign cnt_dec = e_count - CW'(1);
  assign mod_sh  = {rem_r, prod_r[bit_r]};
  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    we            = 1'b0;
    waddr         = slot_r;
    wdata         = '0;
    finish        = 1'b0;
    res_status    = ST_OK;
    res_count     = '0;
    res_owned     = 1'b0;
    res_slot      = '0;

    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_req.operation > OP_REM) ? S_PROBE : S_HASH;
        end
      end
      S_HASH: begin
        n_nxt = '0;
        if (POW2) begin
          slot_nxt  = prod_r[IW-1:0];
          state_nxt = S_PROBE;
        end else begin
          rem_nxt   = '0;
          bit_nxt   = 5'd31;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_sh >= (IW+1)'(TABLE_ENTRIES)) begin
          rem_nxt = IW'(mod_sh - (IW+1)'(TABLE_ENTRIES));
        end else begin
          rem_nxt = IW'(mod_sh);
        end
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          slot_nxt  = rem_nxt;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (op_r > OP_REM) begin
          finish = 1'b1;
        end else if (!e_stop && !e_last) begin
          slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + IW'(1);
          n_nxt    = n_r + IW'(1);
        end else begin
          finish     = 1'b1;
          res_status = e_match ? ST_OK : (e_valid ? ST_FULL : ST_MISS);
          res_slot   = e_stop ? slot_r : '0;
          if (op_r == OP_SET) begin
            if (e_stop) begin
              we    = 1'b1;
              wdata = {1'b1, own_r, val_r, key_r};
              if (!e_valid) begin
                free_nxt = free_r - FW'(1);
              end
              res_status = ST_OK;
            end
          end else if (e_match) begin
            priority if (op_r == OP_INC) begin
              we    = 1'b1;
              wdata = {rd[EW-1:KEY_W+CW], (e_count == CNT_MAX) ? e_count : e_count + CW'(1),
                       e_frame};
            end else if (op_r == OP_GET) begin
              res_count = e_count;
              res_owned = e_owned;
            end else if (op_r == OP_DEC) begin
              res_owned = e_owned;
              if (e_count != '0) begin
                res_count = cnt_dec;
                we        = 1'b1;
                if (cnt_dec == '0) begin
                  wdata    = '0;
                  free_nxt = free_r + FW'(1);
                end else begin
                  wdata = {rd[EW-1:KEY_W+CW], cnt_dec, e_frame};
                end
              end
            end else begin
              we       = 1'b1;
              wdata    = '0;
              free_nxt = free_r + FW'(1);
            end
          end
        end
        if (finish && !out_free) begin
          finish   = 1'b0;
          we       = 1'b0;
          free_nxt = free_r;
          slot_nxt = slot_r;
          n_nxt    = n_r;
        end else if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      free_r      <= FW'(TABLE_ENTRIES);
      out_valid_r <= 1'b0;
      slot_r      <= '0;
      n_r         <= '0;
      rem_r       <= '0;
      bit_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
      n_r         <= n_nxt;
      rem_r       <= rem_nxt;
      bit_r       <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req.operation;
      key_r  <= in_req.frame_addr;
      val_r  <= CW'(in_req.ref_value);
      own_r  <= in_req.owned_in;
      prod_r <= KEY_W'(in_req.frame_addr * HASH_MULT);
    end
    if (finish) begin
      out_status_r <= res_status;
      out_count_r  <= CNT_O_W'(res_count);
      out_owned_r  <= res_owned;
      out_slot_r   <= SLOT_W'(res_slot);
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.ref_count  = out_count_r;
  assign out_rsp.owned_out  = out_owned_r;
  assign out_rsp.slot_index = out_slot_r;
  assign out_rsp.free_slots = FREE_W'(free_r);

endmodule

// ===== rtl/cowrt_chk.sv =====
module cowrt_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cowrt_pkg::ST_W-1:0]    status,
  input logic [cowrt_pkg::CNT_O_W-1:0] ref_count,
  input logic                         owned_out,
  input logic [cowrt_pkg::SLOT_W-1:0]  slot_index,
  input logic [cowrt_pkg::FREE_W-1:0]  free_slots
);
  import cowrt_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready in the cycle after a transaction was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_OK || status == ST_MISS || status == ST_FULL)
    else $error("undefined status code");

  a_full_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> slot_index == '0 && free_slots == '0)
    else $error("full status with free slots or a slot index");

  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_MISS |-> ref_count == '0 && !owned_out && free_slots != '0)
    else $error("miss result carries count, owned flag or no free slot");

endmodule

bind cow_frame_refcount_table_top cowrt_chk u_cowrt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .status     (out_rsp.status),
  .ref_count  (out_rsp.ref_count),
  .owned_out  (out_rsp.owned_out),
  .slot_index (out_rsp.slot_index),
  .free_slots (out_rsp.free_slots)
);

// ===== dv/cow_frame_refcount_table_top_test.sv =====
module cow_frame_refcount_table_top_test;
  import cowrt_pkg::*;

  localparam int TABLE_SLOTS    = DEF_TABLE_ENTRIES;
  localparam int RANDOM_ITEMS   = 450;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = DEF_TABLE_ENTRIES + 64;
  localparam int REPORT_MAX     = 10;

  localparam logic [OP_W-1:0] OP_RSV_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_RSV_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_RSV_HI  = 3'd7;

  localparam logic [CNT_O_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [CNT_O_W-1:0] ref_count;
    logic               owned;
    logic [SLOT_W-1:0]  slot_index;
    logic [FREE_W-1:0]  free_slots;
  } table_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] frame;
    logic [VAL_W-1:0] value;
    logic             owned;
    logic             typed;
    table_rsp_t       want;
  } frame_req_t;

  logic clk;
  logic rst_n;

  cowrt_req_if req_ch ();
  cowrt_rsp_if rsp_ch ();

  cow_frame_refcount_table_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  logic [KEY_W-1:0]   slot_frame [TABLE_SLOTS];
  logic [CNT_O_W-1:0] slot_count [TABLE_SLOTS];
  logic               slot_owned [TABLE_SLOTS];
  logic               slot_valid [TABLE_SLOTS];
  logic [SLOT_W-1:0]  home_inv   [TABLE_SLOTS];
  int                 free_total;

  table_rsp_t       awaited_results [$];
  logic [KEY_W-1:0] hot_frames [$];
  int               calm_left [2];
  int               mismatches;
  int               stall_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] frame);
    logic [KEY_W-1:0] prod;
    prod = frame * HASH_MULT;
    return prod[SLOT_W-1:0];
  endfunction

  function automatic table_rsp_t apply_frame_op(input logic [OP_W-1:0] op,
                                                input logic [KEY_W-1:0] frame,
                                                input logic [VAL_W-1:0] value,
                                                input logic owned);
    table_rsp_t        r;
    logic [SLOT_W-1:0] s;
    logic [ST_W-1:0]   st;
    logic              stopped;
    logic              vacate;
    int                n;
    r = '0;
    vacate = 1'b0;
    if (op <= OP_REM) begin
      s = home_slot(frame);
      st = ST_FULL;
      stopped = 1'b0;
      for (n = 0; n < TABLE_SLOTS && !stopped; n++) begin
        if (!slot_valid[s]) begin
          st = ST_MISS;
          stopped = 1'b1;
        end else if (slot_frame[s] == frame) begin
          st = ST_OK;
          stopped = 1'b1;
        end else begin
          s = s + 1'b1;
        end
      end
      if (st == ST_FULL) s = '0;
      r.status = st;
      r.slot_index = s;
      if (op == OP_SET) begin
        if (st != ST_FULL) begin
          if (st == ST_MISS) begin
            slot_frame[s] = frame;
            slot_valid[s] = 1'b1;
            free_total--;
          end
          slot_count[s] = value;
          slot_owned[s] = owned;
          r.status = ST_OK;
        end
      end else if (st == ST_OK) begin
        case (op)
          OP_INC: if (slot_count[s] != COUNT_TOP) slot_count[s] = slot_count[s] + 1'b1;
          OP_GET: begin
            r.ref_count = slot_count[s];
            r.owned = slot_owned[s];
          end
          OP_DEC: begin
            r.owned = slot_owned[s];
            if (slot_count[s] != '0) begin
              slot_count[s] = slot_count[s] - 1'b1;
              r.ref_count = slot_count[s];
              if (slot_count[s] == '0) vacate = 1'b1;
            end
          end
          default: vacate = 1'b1;
        endcase
        if (vacate) begin
          slot_frame[s] = '0;
          slot_count[s] = '0;
          slot_owned[s] = 1'b0;
          slot_valid[s] = 1'b0;
          free_total++;
        end
      end
    end
    r.free_slots = free_total[FREE_W-1:0];
    return r;
  endfunction

  function automatic frame_req_t req_row(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] frame,
                                         input logic [VAL_W-1:0] value,
                                         input logic owned);
    frame_req_t rq;
    rq = '0;
    rq.op = op;
    rq.frame = frame;
    rq.value = value;
    rq.owned = owned;
    return rq;
  endfunction

  function automatic frame_req_t checked_row(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] frame,
                                             input logic [VAL_W-1:0] value,
                                             input logic owned,
                                             input logic [ST_W-1:0] st,
                                             input logic [CNT_O_W-1:0] cnt,
                                             input logic own_out,
                                             input logic [SLOT_W-1:0] slot,
                                             input logic [FREE_W-1:0] free_n);
    frame_req_t rq;
    rq = req_row(op, frame, value, owned);
    rq.typed = 1'b1;
    rq.want.status = st;
    rq.want.ref_count = cnt;
    rq.want.owned = own_out;
    rq.want.slot_index = slot;
    rq.want.free_slots = free_n;
    return rq;
  endfunction

  // mostly reuse recent keys so that hits dominate; page-aligned keys pile onto slot 0
  function automatic frame_req_t random_req();
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] frame;
    logic [VAL_W-1:0] value;
    int               roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) op = OP_SET;
    else if (roll < 40) op = OP_INC;
    else if (roll < 60) op = OP_GET;
    else if (roll < 82) op = OP_DEC;
    else if (roll < 95) op = OP_REM;
    else op = $urandom_range(OP_RSV_LO, OP_RSV_HI);
    roll = $urandom_range(0, 99);
    if (hot_frames.size() != 0 && roll < 65)
      frame = hot_frames[$urandom_range(0, hot_frames.size() - 1)];
    else if (roll < 80) frame = $urandom() & 32'hFFFF_F000;
    else frame = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 45) value = $urandom_range(0, 3);
    else if (roll < 55) value = COUNT_TOP - $urandom_range(0, 1);
    else value = $urandom();
    if (op == OP_SET) begin
      hot_frames.push_back(frame);
      if (hot_frames.size() > 40) hot_frames.delete(0);
    end
    return req_row(op, frame, value, $urandom_range(0, 1));
  endfunction

  function automatic int idle_draw(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left[side] = $urandom_range(8, 40);
    return $urandom_range(0, 6);
  endfunction

  task automatic issue_frame_op(input frame_req_t rq);
    int         gap;
    table_rsp_t predicted;
    gap = idle_draw(0);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= rq.op;
    req_ch.frame_addr <= rq.frame;
    req_ch.ref_value  <= rq.value;
    req_ch.owned_in   <= rq.owned;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_frame_op(rq.op, rq.frame, rq.value, rq.owned);
    awaited_results.push_back(rq.typed ? rq.want : predicted);
  endtask

  task automatic check_result(input table_rsp_t got);
    table_rsp_t want;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result: st=%0d cnt=%h own=%0d slot=%0d free=%0d",
                 got.status, got.ref_count, got.owned, got.slot_index, got.free_slots);
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.ref_count !== want.ref_count ||
          got.owned !== want.owned || got.slot_index !== want.slot_index ||
          got.free_slots !== want.free_slots) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result mismatch: expected st=%0d cnt=%h own=%0d slot=%0d free=%0d, got st=%0d cnt=%h own=%0d slot=%0d free=%0d",
                   want.status, want.ref_count, want.owned, want.slot_index,
                   want.free_slots, got.status, got.ref_count, got.owned,
                   got.slot_index, got.free_slots);
      end
    end
  endtask

  initial begin
    table_rsp_t got;
    int         gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_draw(1);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.status = rsp_ch.status;
      got.ref_count = rsp_ch.ref_count;
      got.owned = rsp_ch.owned_out;
      got.slot_index = rsp_ch.slot_index;
      got.free_slots = rsp_ch.free_slots;
      check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("cow_frame_refcount_table_top_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    frame_req_t       dir_rows [$];
    int               i;
    int               idx;
    logic [KEY_W-1:0] k;
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_SET;
    req_ch.frame_addr <= '0;
    req_ch.ref_value  <= '0;
    req_ch.owned_in   <= 1'b0;
    stall_cycles = 0;
    mismatches = 0;
    calm_left[0] = 0;
    calm_left[1] = 0;
    free_total = TABLE_SLOTS;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      slot_frame[i] = '0;
      slot_count[i] = '0;
      slot_owned[i] = 1'b0;
      slot_valid[i] = 1'b0;
      home_inv[home_slot(i)] = i[SLOT_W-1:0];
    end

    dir_rows.push_back(checked_row(OP_GET, 32'h0000_0000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd0, 12'd2048));
    dir_rows.push_back(checked_row(OP_SET, 32'h0000_0000, 16'hFFFF, 1'b1,
                                   ST_OK, 16'h0000, 1'b0, 11'd0, 12'd2047));
    dir_rows.push_back(checked_row(OP_INC, 32'h0000_0000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd0, 12'd2047));
    dir_rows.push_back(checked_row(OP_GET, 32'h0000_0000, 16'h0000, 1'b0,
                                   ST_OK, 16'hFFFF, 1'b1, 11'd0, 12'd2047));
    // page-aligned keys all start at slot 0
    dir_rows.push_back(checked_row(OP_SET, 32'h0000_1000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_DEC, 32'h0000_1000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_INC, 32'h0000_1000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_DEC, 32'h0000_1000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2047));
    dir_rows.push_back(checked_row(OP_GET, 32'h0000_1000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd1, 12'd2047));
    dir_rows.push_back(checked_row(OP_SET, 32'h0000_2000, 16'h0001, 1'b1,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_SET, 32'h0000_3000, 16'h0002, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd2, 12'd2045));
    dir_rows.push_back(checked_row(OP_REM, 32'h0000_2000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2046));
    // no tombstone: the entry beyond the hole is lost to lookups
    dir_rows.push_back(checked_row(OP_GET, 32'h0000_3000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_INC, 32'h0000_5000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_DEC, 32'h0000_5000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_REM, 32'h0000_5000, 16'h0000, 1'b0,
                                   ST_MISS, 16'h0000, 1'b0, 11'd1, 12'd2046));
    dir_rows.push_back(checked_row(OP_RSV_LO, 32'h0000_0000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0000, 1'b0, 11'd0, 12'd2046));
    dir_rows.push_back(checked_row(OP_RSV_MID, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                                   ST_OK, 16'h0000, 1'b0, 11'd0, 12'd2046));
    dir_rows.push_back(checked_row(OP_RSV_HI, 32'h0000_1000, 16'h1234, 1'b1,
                                   ST_OK, 16'h0000, 1'b0, 11'd0, 12'd2046));
    dir_rows.push_back(req_row(OP_SET, 32'hFFFF_FFFF, 16'h8000, 1'b1));
    dir_rows.push_back(req_row(OP_SET, 32'hFFFF_FFFF, 16'h7FFF, 1'b0));
    dir_rows.push_back(req_row(OP_GET, 32'hFFFF_FFFF, 16'h0000, 1'b0));
    dir_rows.push_back(checked_row(OP_DEC, 32'h0000_0000, 16'h0000, 1'b0,
                                   ST_OK, 16'hFFFE, 1'b1, 11'd0, 12'd2045));
    dir_rows.push_back(checked_row(OP_SET, 32'h0000_3000, 16'h0005, 1'b1,
                                   ST_OK, 16'h0000, 1'b0, 11'd1, 12'd2044));
    dir_rows.push_back(checked_row(OP_GET, 32'h0000_3000, 16'h0000, 1'b0,
                                   ST_OK, 16'h0005, 1'b1, 11'd1, 12'd2044));
    dir_rows.push_back(req_row(OP_GET, 32'hAAAA_5555, 16'h5555, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < dir_rows.size(); i++) issue_frame_op(dir_rows[i]);
    repeat (RANDOM_ITEMS) issue_frame_op(random_req());

    // fill every free slot with a key that lands on it directly
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (!slot_valid[i]) begin
        k = $urandom();
        k[SLOT_W-1:0] = home_inv[i];
        issue_frame_op(req_row(OP_SET, k, $urandom(), $urandom_range(0, 1)));
      end
    end
    issue_frame_op(req_row(OP_SET, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_INC, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_GET, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_DEC, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_REM, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_RSV_MID, $urandom(), $urandom(), $urandom_range(0, 1)));
    idx = $urandom_range(0, TABLE_SLOTS - 1);
    k = slot_frame[idx];
    issue_frame_op(req_row(OP_GET, k, 16'h0000, 1'b0));
    issue_frame_op(req_row(OP_INC, k, 16'h0000, 1'b0));
    issue_frame_op(req_row(OP_DEC, k, 16'h0000, 1'b0));
    issue_frame_op(req_row(OP_REM, k, 16'h0000, 1'b0));
    issue_frame_op(req_row(OP_SET, $urandom(), $urandom(), $urandom_range(0, 1)));
    issue_frame_op(req_row(OP_GET, $urandom(), $urandom(), $urandom_range(0, 1)));
    repeat (12) issue_frame_op(random_req());
    req_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += awaited_results.size();
    if (mismatches == 0) begin
      $display("cow_frame_refcount_table_top_test OK");
    end else begin
      $display("cow_frame_refcount_table_top_test NOT OK");
    end
    $finish;
  end

endmodule
